FILE: src/egf_pkg.sv
// Shared types, constants and coefficient functions of the edge gradient filter.
package egf_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int VAL_W      = 23;
	localparam int SUM_W      = 36;
	localparam int SQ_W       = 72;
	localparam int ROOT_W     = 36;

	localparam logic [2:0] MODE_ROBERTS = 3'd0;
	localparam logic [2:0] MODE_PREWITT = 3'd1;
	localparam logic [2:0] MODE_SOBEL   = 3'd2;
	localparam logic [2:0] MODE_FREI    = 3'd3;
	localparam logic [2:0] MODE_ISO     = 3'd4;
	localparam logic [2:0] MODE_LAPLACE = 3'd5;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic signed [17:0] coef_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
		logic             eof;
	} tag_t;

	// column of a tap in the 3x3 window, taps in row-major order
	function automatic logic [1:0] tap_col(input logic [3:0] i);
		logic [1:0] c;
		unique case (i)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] tap_row(input logic [3:0] i);
		logic [1:0] r;
		if (i < 4'd3) r = 2'd0;
		else if (i < 4'd6) r = 2'd1;
		else r = 2'd2;
		return r;
	endfunction

	function automatic coef_t kx(input logic [2:0] m, input logic [3:0] i);
		coef_t k;
		logic [1:0] cc;
		k  = '0;
		cc = tap_col(i);
		unique case (m)
			MODE_ROBERTS: k = (i == 5) ? 18'sd16384 : (i == 7) ? -18'sd16384 : 18'sd0;
			MODE_PREWITT: k = (cc == 0) ? 18'sd5461 : (cc == 2) ? -18'sd5461 : 18'sd0;
			MODE_SOBEL: begin
				if (cc == 1) k = 18'sd0;
				else if (i == 3) k = 18'sd8192;
				else if (i == 5) k = -18'sd8192;
				else k = (cc == 0) ? 18'sd4096 : -18'sd4096;
			end
			MODE_FREI: begin
				if (cc == 1) k = 18'sd0;
				else if (i == 3) k = 18'sd6786;
				else if (i == 5) k = -18'sd6786;
				else k = (cc == 0) ? 18'sd4799 : -18'sd4799;
			end
			MODE_ISO: begin
				if (cc == 1) k = 18'sd0;
				else if (i == 3) k = -18'sd3393;
				else if (i == 5) k = 18'sd3393;
				else k = (cc == 0) ? -18'sd2399 : 18'sd2399;
			end
			MODE_LAPLACE: k = (i == 4) ? -18'sd43691 : 18'sd5461;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic coef_t ky(input logic [2:0] m, input logic [3:0] i);
		coef_t k;
		logic [1:0] rr;
		logic [1:0] cc;
		k  = '0;
		rr = tap_row(i);
		cc = tap_col(i);
		unique case (m)
			MODE_ROBERTS: k = (i == 0) ? -18'sd16384 : (i == 4) ? 18'sd16384 : 18'sd0;
			MODE_PREWITT: k = (rr == 0) ? -18'sd5461 : (rr == 2) ? 18'sd5461 : 18'sd0;
			MODE_SOBEL: k = (rr == 1) ? 18'sd0 : (cc == 1) ? 18'sd8192 : 18'sd4096;
			MODE_FREI: k = (rr == 1) ? 18'sd0 : (cc == 1) ? 18'sd6786 : 18'sd4799;
			MODE_ISO: k = (rr == 1) ? 18'sd0 : (cc == 1) ? 18'sd3393 : 18'sd2399;
			default: k = '0;
		endcase
		if (rr == 0 && m != MODE_ROBERTS && m != MODE_PREWITT) k = -k;
		return k;
	endfunction
endpackage

FILE: src/egf_isqrt.sv
// Iterative floor square root, two result bits per cycle.
module egf_isqrt
	import egf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int STEPS = ROOT_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [SQ_W-1:0]   rem_q;
	logic [SQ_W-1:0]   val_q;
	logic [ROOT_W-1:0] res_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [SQ_W+1:0]   r1, t1, r2, t2;
	logic [ROOT_W-1:0] q1, q2;
	logic [SQ_W-1:0]   v1;

	always_comb begin
		r1 = {rem_q, val_q[SQ_W-1:SQ_W-2]};
		t1 = {res_q, 2'b01};
		if (r1 >= t1) begin
			r1 = r1 - t1;
			q1 = {res_q[ROOT_W-2:0], 1'b1};
		end else begin
			q1 = {res_q[ROOT_W-2:0], 1'b0};
		end
		v1 = {val_q[SQ_W-3:0], 2'b00};
		r2 = {r1[SQ_W-1:0], v1[SQ_W-1:SQ_W-2]};
		t2 = {q1, 2'b01};
		if (r2 >= t2) begin
			r2 = r2 - t2;
			q2 = {q1[ROOT_W-2:0], 1'b1};
		end else begin
			q2 = {q1[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			val_q <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2[SQ_W-1:0];
			val_q <= {v1[SQ_W-3:0], 2'b00};
			res_q <= q2;
		end
	end

	assign done = busy_q && cnt_q == CNT_W'(1);
	assign root = q2;
endmodule

FILE: src/edge_gradient_3x3_filter.sv
// Top level of the 3x3 edge gradient filter with line buffer memories.
// Per input beat the line memories are read; at column 0 or row 0 the window only
// steps, else each result job runs the nine multiply-accumulate taps, starts the
// square root and waits for it, then outputs (Laplace skips the square root). A held
// result beat stalls the next one. Reset clears counters, state, window and valid
// flags and sets defaults; line memories are not cleared (row 0 fills them first).
module edge_gradient_3x3_filter
	import egf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [PIX_W-1:0] pixel,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] value,
	output logic [COL_W-1:0]        out_col,
	output logic [ROW_W-1:0]        out_row,
	output logic                    last_in_run,
	output logic                    end_of_frame,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [12:0]             cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_PLAN = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_NEXT = 3'd6;

	logic [2:0]       mode_q;
	logic [10:0]      width_q;
	logic [12:0]      height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [2:0]       st_q;
	pix_t             pix_q;
	pix_t             win_q [6];
	pix_t             cur_q [3];
	pix_t             older_mem [MAX_WIDTH];
	pix_t             newer_mem [MAX_WIDTH];
	pix_t             old_rd_q, new_rd_q;
	logic [1:0]       job_q, njobs_q;
	logic [3:0]       tap_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic signed [VAL_W-1:0] res_q;
	logic signed [VAL_W-1:0] oval_q;
	tag_t             tag_q;
	logic             ovalid_q;
	logic             sq_go_q;
	logic             last_col, last_row, sq_start, sq_done;
	logic [11:0]      wd;
	logic [13:0]      ht;
	pix_t             cur_r0, cur_r1;
	pix_t             wl [3], wm [3], wr [3];
	pix_t             tapv;
	logic signed [SUM_W-1:0] px, py, lap;
	logic signed [31:0] sx32, sy32;
	logic signed [63:0] sxx, syy;
	logic [SQ_W-1:0]  sq;
	logic [ROOT_W-1:0] root;
	logic [ROOT_W-11:0] mag;
	logic [1:0]       phys_job;

	always_comb begin
		wd = {1'b0, width_q};
		if (wd < 12'd2) wd = 12'd2;
		if (wd > 12'(MAX_WIDTH)) wd = 12'(MAX_WIDTH);
		ht = {1'b0, height_q};
		if (ht < 14'd2) ht = 14'd2;
		if (ht > 14'(MAX_HEIGHT)) ht = 14'(MAX_HEIGHT);
	end
	assign last_col = 12'(col_q) == wd - 12'd1;
	assign last_row = 14'(row_q) == ht - 14'd1;

	assign cur_r0 = (row_q == '0) ? pix_q : old_rd_q;
	assign cur_r1 = (row_q == '0) ? pix_q : new_rd_q;

	// map sequence index to job kind: without last col, index 1 is lower
	always_comb begin
		if (last_col) phys_job = job_q;
		else phys_job = (job_q == 2'd1) ? 2'd2 : 2'd0;
	end

	// window for job: 0 (two,one,cur) 1 (one,cur,cur) 2/3 lowered
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unique case (phys_job)
				2'd0: begin wl[i] = win_q[3+i]; wm[i] = win_q[i]; wr[i] = cur_q[i]; end
				2'd1: begin wl[i] = win_q[i]; wm[i] = cur_q[i]; wr[i] = cur_q[i]; end
				2'd2: begin
					wl[i] = win_q[3+((i == 0) ? 1 : 2)];
					wm[i] = win_q[(i == 0) ? 1 : 2];
					wr[i] = cur_q[(i == 0) ? 1 : 2];
				end
				default: begin
					wl[i] = win_q[(i == 0) ? 1 : 2];
					wm[i] = cur_q[(i == 0) ? 1 : 2];
					wr[i] = cur_q[(i == 0) ? 1 : 2];
				end
			endcase
		end
		unique case (tap_col(tap_q))
			2'd0: tapv = wl[tap_row(tap_q)];
			2'd1: tapv = wm[tap_row(tap_q)];
			default: tapv = wr[tap_row(tap_q)];
		endcase
	end

	// job list: when last col, jobs 0,1, plus 2,3 on last row; njobs_q holds last index
	always_comb begin
		px   = SUM_W'(tapv * kx(mode_q, tap_q));
		py   = SUM_W'(tapv * ky(mode_q, tap_q));
		lap  = (sx_q + SUM_W'(512)) >>> 10;
		sx32 = sx_q[31:0];
		sy32 = sy_q[31:0];
		sxx  = sx32 * sx32;
		syy  = sy32 * sy32;
		sq   = SQ_W'(unsigned'(sxx)) + SQ_W'(unsigned'(syy));
		mag  = root[ROOT_W-1:10];
	end

	egf_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq),
		.done(sq_done), .root(root)
	);
	assign sq_start = sq_go_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			old_rd_q <= older_mem[col_q];
			new_rd_q <= newer_mem[col_q];
		end
		if (st_q == ST_READ) begin
			older_mem[col_q] <= cur_r1;
			newer_mem[col_q] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SOBEL;
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			col_q    <= '0;
			row_q    <= '0;
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			sq_go_q  <= 1'b0;
			job_q    <= '0;
			njobs_q  <= '0;
			tap_q    <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
			for (int i = 0; i < 3; i++) cur_q[i] <= '0;
		end else begin
			if (out_valid && out_ready) ovalid_q <= 1'b0;
			// sums are complete in the cycle after the last tap, so start is registered
			sq_go_q <= st_q == ST_MAC && tap_q == 4'd8 && mode_q < MODE_LAPLACE;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: mode_q <= cfg_data[2:0];
					REG_WIDTH: begin
						width_q <= cfg_data[10:0]; col_q <= '0; row_q <= '0;
					end
					REG_HEIGHT: begin
						height_q <= cfg_data; col_q <= '0; row_q <= '0;
					end
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					pix_q <= pixel;
					st_q <= ST_READ;
				end
				ST_READ: begin
					cur_q[0] <= cur_r0; cur_q[1] <= cur_r1; cur_q[2] <= pix_q;
					if (col_q == '0) begin
						win_q[0] <= cur_r0; win_q[1] <= cur_r1; win_q[2] <= pix_q;
						win_q[3] <= cur_r0; win_q[4] <= cur_r1; win_q[5] <= pix_q;
						st_q <= ST_NEXT;
					end else if (row_q == '0) st_q <= ST_NEXT;
					else st_q <= ST_PLAN;
				end
				ST_PLAN: begin
					// jobs: 0 main, 1 right edge, 2 lower, 3 lower right
					njobs_q <= last_row ? (last_col ? 2'd3 : 2'd1) : (last_col ? 2'd1 : 2'd0);
					job_q <= 2'd0; tap_q <= '0; sx_q <= '0; sy_q <= '0;
					st_q <= ST_MAC;
				end
				ST_MAC: begin
					sx_q <= sx_q + px;
					sy_q <= sy_q + py;
					tap_q <= tap_q + 4'd1;
					if (tap_q == 4'd8) st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (mode_q > MODE_LAPLACE) begin
						res_q <= '0; st_q <= ST_OUT;
					end else if (mode_q == MODE_LAPLACE) begin
						res_q <= (lap > SUM_W'(4194303)) ? 23'sd4194303 :
							(lap < -SUM_W'(4194304)) ? -23'sd4194304 : VAL_W'(lap);
						st_q <= ST_OUT;
					end else if (sq_done) begin
						res_q <= (mag > (ROOT_W-10)'(4194303)) ? 23'sd4194303 : VAL_W'(mag);
						st_q <= ST_OUT;
					end
				end
				ST_OUT: if (!ovalid_q) begin
					ovalid_q <= 1'b1;
					oval_q <= res_q;
					tag_q.col <= (phys_job[0]) ? col_q : col_q - 1'b1;
					tag_q.row <= (phys_job[1]) ? row_q : row_q - 1'b1;
					tag_q.last <= job_q == njobs_q;
					tag_q.eof <= phys_job == 2'd3;
					if (job_q == njobs_q) st_q <= ST_NEXT;
					else begin
						job_q <= job_q + 2'd1; tap_q <= '0; sx_q <= '0; sy_q <= '0;
						st_q <= ST_MAC;
					end
				end
				ST_NEXT: begin
					if (col_q != '0) begin
						win_q[3] <= win_q[0]; win_q[4] <= win_q[1]; win_q[5] <= win_q[2];
						win_q[0] <= cur_q[0]; win_q[1] <= cur_q[1]; win_q[2] <= cur_q[2];
					end
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = st_q == ST_IDLE;
	assign out_valid    = ovalid_q;
	assign value        = oval_q;
	assign out_col      = tag_q.col;
	assign out_row      = tag_q.row;
	assign last_in_run  = tag_q.last;
	assign end_of_frame = tag_q.eof;

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_in_run) else $error("eof without last");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !in_ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value)) else $error("result lost");
endmodule
